[sv/ppts_pkg.sv]
// Package for the perspective projection block.
// Holds shared widths, command and register codes, the result record and helpers.
// No dependencies.
package ppts_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DATA_W        = 32;
    localparam int CFG_W         = 14;
    localparam int NUM_COEFS     = 16;
    localparam int COEF_IDX_W    = 4;
    localparam int MID_DEPTH     = 4;
    localparam int OUT_DEPTH     = 4;

    // Input item commands.
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    // Configuration register indexes.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 14'd1920;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 14'd1080;

    localparam logic signed [DATA_W-1:0] MAX_S32 = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MIN_S32 = 32'sh8000_0000;

    // One projected point as it leaves the block.
    typedef struct packed {
        logic signed [DATA_W-1:0] screen_x;
        logic signed [DATA_W-1:0] screen_y;
        logic signed [DATA_W-1:0] depth;
        logic                     behind_camera;
    } ppts_result_t;

    // Width of a clip coordinate: a 64-bit product shifted down, plus carry room.
    function automatic int acc_width(input int frac_bits);
        return 2 * DATA_W - frac_bits + 2;
    endfunction

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'(MAX_S32))
            r = MAX_S32;
        else if (v < 64'(MIN_S32))
            r = MIN_S32;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

[sv/perspective_project_to_screen.sv]
// Top level of the perspective projection block.
// Depends on ppts_pkg, ppts_front, ppts_fifo and ppts_back.
//
// Usage:
//   Input channel: an item is taken when push is high and full is low. cmd
//   selects a coefficient load (no result) or a point projection (one result).
//   Result channel: while empty is low the oldest result is on screen_x,
//   screen_y, depth and behind_camera; pop with empty low takes it.
//   Configuration: cfg_we writes cfg_wdata into the width (index 0) or height
//   (index 1) register at the clock edge; write only while the block is idle.
//   Throughput: one item per cycle while full is low. A load is visible to
//   the very next item. A projection passes a 32-stage divider that forms
//   one quotient bit per stage on its way to the result ports.
//   Stalls: when pop is held low the result queue fills, the back end freezes,
//   the clip queue between front and back fills, and then full rises.
//   Reset: clears the matrix to zero, sets width 1920 and height 1080, and
//   empties both queues.
module perspective_project_to_screen
    import ppts_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic                     cmd,
    input  logic [COEF_IDX_W-1:0]    coef_index,
    input  logic signed [DATA_W-1:0] coef_value,
    input  logic signed [DATA_W-1:0] point_x,
    input  logic signed [DATA_W-1:0] point_y,
    input  logic signed [DATA_W-1:0] point_z,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [DATA_W-1:0] screen_x,
    output logic signed [DATA_W-1:0] screen_y,
    output logic signed [DATA_W-1:0] depth,
    output logic                     behind_camera,
    input  logic                     cfg_we,
    input  logic                     cfg_addr,
    input  logic [CFG_W-1:0]         cfg_wdata
);

    localparam int ACC_W = acc_width(FRAC_BITS);

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic               in_ready;
    logic               clip_valid;
    logic [4*ACC_W-1:0] clip_data;
    logic               clip_full;
    logic               mid_empty;
    logic [4*ACC_W-1:0] mid_data;
    logic               mid_pop;
    logic               res_valid;
    ppts_result_t       res_data;
    logic               res_full;
    ppts_result_t       out_data;

    // Viewport registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WIDTH:  width_reg  <= cfg_wdata;
                REG_HEIGHT: height_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    assign full = !in_ready;

    ppts_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (push),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .clip_valid (clip_valid),
        .clip_data  (clip_data),
        .clip_full  (clip_full)
    );

    // Clip queue decoupling the front and back ends.
    ppts_fifo #(.W(4*ACC_W), .DEPTH(MID_DEPTH)) u_mid_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (clip_valid),
        .push_data (clip_data),
        .full      (clip_full),
        .pop       (mid_pop),
        .pop_data  (mid_data),
        .empty     (mid_empty)
    );

    ppts_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .clip_valid    (!mid_empty),
        .clip_data     (mid_data),
        .clip_pop      (mid_pop),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .res_valid     (res_valid),
        .res_data      (res_data),
        .res_full      (res_full)
    );

    // Result queue.
    ppts_fifo #(.W($bits(ppts_result_t)), .DEPTH(OUT_DEPTH)) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_data),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (out_data),
        .empty     (empty)
    );

    assign screen_x      = out_data.screen_x;
    assign screen_y      = out_data.screen_y;
    assign depth         = out_data.depth;
    assign behind_camera = out_data.behind_camera;

endmodule

[sv/ppts_fifo.sv]
// Small first-in first-out queue built from registers.
// Used between the front and back ends and at the output. Depends on nothing.
module ppts_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    localparam int PW = $clog2(DEPTH);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign count_next = count_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            count_reg <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data = mem_reg[rd_ptr_reg];

endmodule

[sv/ppts_front.sv]
// Front end: accepts items, keeps the view matrix, forms the four clip coordinates.
// Uses ppts_pkg. Feeds the clip queue toward the back end.
module ppts_front
    import ppts_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 cmd,
    input  logic [COEF_IDX_W-1:0]                coef_index,
    input  logic signed [DATA_W-1:0]             coef_value,
    input  logic signed [DATA_W-1:0]             point_x,
    input  logic signed [DATA_W-1:0]             point_y,
    input  logic signed [DATA_W-1:0]             point_z,
    output logic                                 clip_valid,
    output logic [4*acc_width(FRAC_BITS)-1:0]    clip_data,
    input  logic                                 clip_full
);

    localparam int ACC_W = acc_width(FRAC_BITS);

    logic signed [DATA_W-1:0]   coef_reg [NUM_COEFS];
    logic signed [2*DATA_W-1:0] prod_reg [4][3];
    logic signed [DATA_W-1:0]   trans_reg [4];
    logic                       p_valid_reg;
    logic signed [DATA_W-1:0]   pt [3];
    logic signed [ACC_W-1:0]    clip [4];
    logic                       adv;
    logic                       accept;

    assign adv      = !clip_full;
    assign in_ready = adv;
    assign accept   = in_valid && adv;

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    // Coefficient store, cleared at reset, written by load items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
                coef_reg[i] <= '0;
        end
        else if (accept && cmd == CMD_LOAD)
        begin
            coef_reg[coef_index] <= coef_value;
        end
    end

    // Product stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (adv)
            p_valid_reg <= accept && cmd == CMD_PROJECT;
    end

    // Twelve products of point coordinates and matrix coefficients.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= pt[c] * coef_reg[r*4+c];
                trans_reg[r] <= coef_reg[r*4+3];
            end
        end
    end

    // Row sums: each product is floored to the fixed-point grid.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            clip[r] = ACC_W'(trans_reg[r])
                    + ACC_W'(prod_reg[r][0] >>> FRAC_BITS)
                    + ACC_W'(prod_reg[r][1] >>> FRAC_BITS)
                    + ACC_W'(prod_reg[r][2] >>> FRAC_BITS);
        end
    end

    assign clip_valid = p_valid_reg;
    assign clip_data  = {clip[3], clip[2], clip[1], clip[0]};

endmodule

[sv/ppts_back.sv]
// Back end: behind-camera test, pipelined division by w and viewport mapping.
// Uses ppts_pkg. Reads the clip queue and writes the result queue.
module ppts_back
    import ppts_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clip_valid,
    input  logic [4*acc_width(FRAC_BITS)-1:0] clip_data,
    output logic                              clip_pop,
    input  logic [CFG_W-1:0]                  screen_width,
    input  logic [CFG_W-1:0]                  screen_height,
    output logic                              res_valid,
    output ppts_result_t                      res_data,
    input  logic                              res_full
);

    localparam int ACC_W   = acc_width(FRAC_BITS);
    localparam int RW      = ACC_W + DATA_W;
    localparam int NS      = DATA_W;
    localparam int MW      = DATA_W + 2 + CFG_W + 1;
    localparam longint THR_RAW = ((longint'(1) << FRAC_BITS) + 500) / 1000;
    localparam longint THR     = (THR_RAW < 1) ? 1 : THR_RAW;
    localparam logic signed [DATA_W+1:0] ONE_EXT = (DATA_W+2)'(longint'(1) << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] NEG_ONE = DATA_W'(-(longint'(1) << FRAC_BITS));

    logic adv;
    logic take;

    // Division pipeline: index 0 is the prepare stage, index s handled quotient bit NS-s.
    logic              st_valid_reg  [NS+1];
    logic              st_behind_reg [NS+1];
    logic [2:0]        st_neg_reg    [NS+1];
    logic [RW-1:0]     st_div_reg    [NS+1];
    logic [RW-1:0]     st_rem_reg    [NS+1][3];
    logic [DATA_W-1:0] st_quo_reg    [NS+1][3];

    logic signed [ACC_W-1:0] c [4];

    logic                     fin_valid_reg;
    logic                     fin_behind_reg;
    logic signed [DATA_W-1:0] fin_q_reg [3];
    logic signed [DATA_W-1:0] fin_q [3];

    logic                     mul_valid_reg;
    logic                     mul_behind_reg;
    logic signed [MW-1:0]     mx_reg;
    logic signed [MW-1:0]     my_reg;
    logic signed [DATA_W-1:0] nz_reg;
    logic signed [DATA_W+1:0] ax;
    logic signed [DATA_W+1:0] ay;

    logic signed [DATA_W-1:0] sx;
    logic signed [DATA_W-1:0] sy;

    // The whole back end moves together whenever the result queue has room.
    assign adv      = !res_full;
    assign clip_pop = adv;
    assign take     = clip_valid && adv;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
            c[r] = clip_data[r*ACC_W +: ACC_W];
    end

    // Prepare stage: behind test, signs, magnitudes scaled by the fraction width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg[0] <= 1'b0;
        else if (adv)
            st_valid_reg[0] <= take;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_behind_reg[0] <= (c[3] < ACC_W'(THR));
            st_div_reg[0]    <= RW'(unsigned'(c[3]));
            for (int j = 0; j < 3; j++)
            begin
                st_neg_reg[0][j] <= c[j][ACC_W-1];
                st_rem_reg[0][j] <= RW'(unsigned'(c[j][ACC_W-1] ? -c[j] : c[j])) << FRAC_BITS;
                st_quo_reg[0][j] <= '0;
            end
        end
    end

    // Restoring division, one quotient bit per stage. The top bit flags saturation.
    for (genvar s = 1; s <= NS; s++)
    begin : g_div
        localparam int BIT = NS - s;
        logic [RW:0]       diff [3];
        logic [DATA_W-1:0] quo_next [3];

        always_comb
        begin
            for (int j = 0; j < 3; j++)
            begin
                diff[j] = {1'b0, st_rem_reg[s-1][j]} - {1'b0, st_div_reg[s-1] << BIT};
                quo_next[j] = st_quo_reg[s-1][j];
                quo_next[j][BIT] = !diff[j][RW];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_valid_reg[s] <= 1'b0;
            else if (adv)
                st_valid_reg[s] <= st_valid_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_behind_reg[s] <= st_behind_reg[s-1];
                st_neg_reg[s]    <= st_neg_reg[s-1];
                st_div_reg[s]    <= st_div_reg[s-1];
                for (int j = 0; j < 3; j++)
                begin
                    st_rem_reg[s][j] <= diff[j][RW] ? st_rem_reg[s-1][j] : diff[j][RW-1:0];
                    st_quo_reg[s][j] <= quo_next[j];
                end
            end
        end
    end

    // Signed, saturated normalized coordinates.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (st_quo_reg[NS][j][DATA_W-1])
                fin_q[j] = st_neg_reg[NS][j] ? MIN_S32 : MAX_S32;
            else if (st_neg_reg[NS][j])
                fin_q[j] = -signed'({1'b0, st_quo_reg[NS][j][DATA_W-2:0]});
            else
                fin_q[j] = signed'({1'b0, st_quo_reg[NS][j][DATA_W-2:0]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            fin_valid_reg <= st_valid_reg[NS];
            mul_valid_reg <= fin_valid_reg;
        end
    end

    // Viewport offsets: x + 1 and 1 - y.
    assign ax = ONE_EXT + (DATA_W+2)'(fin_q_reg[0]);
    assign ay = ONE_EXT - (DATA_W+2)'(fin_q_reg[1]);

    // Quotient register, then viewport scaling products.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fin_behind_reg <= st_behind_reg[NS];
            fin_q_reg      <= fin_q;
            mul_behind_reg <= fin_behind_reg;
            mx_reg         <= ax * signed'({1'b0, screen_width});
            my_reg         <= ay * signed'({1'b0, screen_height});
            nz_reg         <= fin_q_reg[2];
        end
    end

    // Halve with floor rounding and clamp.
    assign sx = sat32(64'(mx_reg >>> 1));
    assign sy = sat32(64'(my_reg >>> 1));

    always_comb
    begin
        if (mul_behind_reg)
        begin
            res_data.screen_x      = '0;
            res_data.screen_y      = '0;
            res_data.depth         = NEG_ONE;
            res_data.behind_camera = 1'b1;
        end
        else
        begin
            res_data.screen_x      = sx;
            res_data.screen_y      = sy;
            res_data.depth         = nz_reg;
            res_data.behind_camera = 1'b0;
        end
    end

    assign res_valid = mul_valid_reg;

endmodule

[sv/ppts_checker.sv]
// Port-level checks for the perspective projection block.
// Uses ppts_pkg; bound to perspective_project_to_screen below.
module ppts_checker
    import ppts_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     full,
    input logic                     empty,
    input logic                     pop,
    input logic signed [DATA_W-1:0] screen_x,
    input logic signed [DATA_W-1:0] screen_y,
    input logic signed [DATA_W-1:0] depth,
    input logic                     behind_camera
);

    // The result queue comes out of reset empty and the input side ready.
    a_empty_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> empty)
        else $error("result queue not empty after reset");

    a_ready_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> !full)
        else $error("input side full after reset");

    // A point behind the camera carries the forced coordinates.
    a_behind_forced: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && behind_camera) |-> (screen_x == '0 && screen_y == '0))
        else $error("behind-camera result with nonzero coordinates");

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(screen_x) && $stable(depth)))
        else $error("waiting result changed");

endmodule

bind perspective_project_to_screen ppts_checker u_ppts_checker (.*);

[tb/sv/perspective_project_to_screen_tb.sv]
// Self-checking testbench for perspective_project_to_screen.
// Drives coefficient loads and point projections through the queue-style ports
// and checks every projected point against an in-bench predictor; needs ppts_pkg.
module perspective_project_to_screen_tb
    import ppts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC      = DEF_FRAC_BITS;
    localparam int  DRAIN_CYC = 60;
    localparam int  CYCLE_CAP = 400000;
    localparam int  RAND_ITEMS = 1400;

    // Predicts projected points and holds the ones still awaited from the block.
    class projection_scoreboard;
        logic signed [DATA_W-1:0] view_matrix [NUM_COEFS];
        logic [CFG_W-1:0]         vp_width;
        logic [CFG_W-1:0]         vp_height;
        ppts_result_t             awaited [$];
        int                       errors;

        function new();
            foreach (view_matrix[i]) view_matrix[i] = '0;
            vp_width  = WIDTH_RESET;
            vp_height = HEIGHT_RESET;
            errors    = 0;
        endfunction

        function void set_reg(logic addr, logic [CFG_W-1:0] value);
            if (addr == REG_WIDTH)
                vp_width = value;
            else
                vp_height = value;
        endfunction

        // Clamp to the signed 32-bit range.
        function longint clamp32(longint v);
            if (v > longint'(MAX_S32))
                return longint'(MAX_S32);
            if (v < longint'(MIN_S32))
                return longint'(MIN_S32);
            return v;
        endfunction

        // Clip coordinate of one matrix row: products floored, sum kept wide.
        function longint row_dot(int row, longint px, longint py, longint pz);
            longint acc;
            acc = longint'(view_matrix[row*4+3]);
            acc += (px * longint'(view_matrix[row*4]))   >>> FRAC;
            acc += (py * longint'(view_matrix[row*4+1])) >>> FRAC;
            acc += (pz * longint'(view_matrix[row*4+2])) >>> FRAC;
            return acc;
        endfunction

        // Fixed-point quotient, truncated toward zero and saturated.
        function longint ndc_div(longint num, longint den);
            bit                neg;
            longint unsigned   a, d, q, r;
            neg = num < 0;
            a = neg ? longint'(-num) : longint'(num);
            d = den;
            q = a / d;
            r = a % d;
            if (q > (64'd1 << 31))
                return neg ? longint'(MIN_S32) : longint'(MAX_S32);
            for (int i = 0; i < FRAC; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= d)
                begin
                    r = r - d;
                    q = q | 64'd1;
                end
            end
            if (neg)
                return (q >= (64'd1 << 31)) ? longint'(MIN_S32) : -longint'(q);
            return (q > 64'h7FFF_FFFF) ? longint'(MAX_S32) : longint'(q);
        endfunction

        // Note an accepted input transfer: loads update the matrix, projections
        // queue their expected point.
        function void note_transfer(logic c, logic [COEF_IDX_W-1:0] idx,
                                    logic signed [DATA_W-1:0] cv,
                                    logic signed [DATA_W-1:0] px,
                                    logic signed [DATA_W-1:0] py,
                                    logic signed [DATA_W-1:0] pz);
            longint       cx, cy, cz, cw, nx, ny, nz, one, thr;
            ppts_result_t exp_pt;
            if (c == CMD_LOAD)
            begin
                view_matrix[idx] = cv;
                return;
            end
            one = longint'(1) << FRAC;
            thr = (one + 500) / 1000;
            if (thr < 1)
                thr = 1;
            cx = row_dot(0, px, py, pz);
            cy = row_dot(1, px, py, pz);
            cz = row_dot(2, px, py, pz);
            cw = row_dot(3, px, py, pz);
            if (cw < thr)
            begin
                exp_pt.screen_x      = '0;
                exp_pt.screen_y      = '0;
                exp_pt.depth         = DATA_W'(-one);
                exp_pt.behind_camera = 1'b1;
            end
            else
            begin
                nx = ndc_div(cx, cw);
                ny = ndc_div(cy, cw);
                nz = ndc_div(cz, cw);
                exp_pt.screen_x = DATA_W'(clamp32(((nx + one) * longint'(vp_width)) >>> 1));
                exp_pt.screen_y = DATA_W'(clamp32(((one - ny) * longint'(vp_height)) >>> 1));
                exp_pt.depth         = DATA_W'(nz);
                exp_pt.behind_camera = 1'b0;
            end
            awaited.insert(awaited.size(), exp_pt);
        endfunction

        // Check one result transfer against the oldest awaited point.
        function void check_transfer(ppts_result_t got);
            ppts_result_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: x=%0d y=%0d", got.screen_x, got.screen_y);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.screen_x !== want.screen_x)
            begin
                $error("screen_x: expected %0d, got %0d", want.screen_x, got.screen_x);
                errors++;
            end
            if (got.screen_y !== want.screen_y)
            begin
                $error("screen_y: expected %0d, got %0d", want.screen_y, got.screen_y);
                errors++;
            end
            if (got.depth !== want.depth)
            begin
                $error("depth: expected %0d, got %0d", want.depth, got.depth);
                errors++;
            end
            if (got.behind_camera !== want.behind_camera)
            begin
                $error("behind_camera: expected %0b, got %0b",
                       want.behind_camera, got.behind_camera);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic                     cmd = CMD_LOAD;
    logic [COEF_IDX_W-1:0]    coef_index = '0;
    logic signed [DATA_W-1:0] coef_value = '0;
    logic signed [DATA_W-1:0] point_x = '0;
    logic signed [DATA_W-1:0] point_y = '0;
    logic signed [DATA_W-1:0] point_z = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic signed [DATA_W-1:0] screen_x;
    logic signed [DATA_W-1:0] screen_y;
    logic signed [DATA_W-1:0] depth;
    logic                     behind_camera;
    logic                     cfg_we = 1'b0;
    logic                     cfg_addr = REG_WIDTH;
    logic [CFG_W-1:0]         cfg_wdata = '0;

    projection_scoreboard sb = new();
    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int cycles = 0;

    perspective_project_to_screen uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd),
        .coef_index(coef_index), .coef_value(coef_value), .point_x(point_x),
        .point_y(point_y), .point_z(point_z), .empty(empty), .pop(pop),
        .screen_x(screen_x), .screen_y(screen_y), .depth(depth),
        .behind_camera(behind_camera), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // Run-length guard.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random pop stalls, every result transfer is checked.
    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= take_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_transfer('{screen_x, screen_y, depth, behind_camera});
    end

    // Offer one item and hold it until the block takes it.
    task automatic send_item(logic c, logic [COEF_IDX_W-1:0] idx,
                             logic signed [DATA_W-1:0] cv,
                             logic signed [DATA_W-1:0] px,
                             logic signed [DATA_W-1:0] py,
                             logic signed [DATA_W-1:0] pz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push       <= 1'b1;
        cmd        <= c;
        coef_index <= idx;
        coef_value <= cv;
        point_x    <= px;
        point_y    <= py;
        point_z    <= pz;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        sb.note_transfer(c, idx, cv, px, py, pz);
    endtask

    // Loads carry random point fields and projections random coefficient fields.
    task automatic load_coef(int idx, logic signed [DATA_W-1:0] cv);
        send_item(CMD_LOAD, COEF_IDX_W'(idx), cv, $urandom, $urandom, $urandom);
    endtask

    task automatic project(logic signed [DATA_W-1:0] px, logic signed [DATA_W-1:0] py,
                           logic signed [DATA_W-1:0] pz);
        send_item(CMD_PROJECT, COEF_IDX_W'($urandom), $urandom, px, py, pz);
    endtask

    // Wait until every awaited point has arrived and the pipeline is quiet.
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
    endtask

    task automatic write_reg(logic addr, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(addr, value);
    endtask

    // Random coefficient near a sensible view transform, now and then full range.
    function automatic logic signed [DATA_W-1:0] view_coef(int idx);
        if ($urandom_range(19) == 0)
            return $urandom;
        if (idx == 15)
            return $urandom_range(8 << FRAC);
        if (idx >= 12)
            return $signed($urandom_range(2 << FRAC)) - (1 << FRAC);
        return $signed($urandom_range(8 << FRAC)) - (4 << FRAC);
    endfunction

    function automatic logic signed [DATA_W-1:0] world_coord();
        if ($urandom_range(15) == 0)
            return $urandom;
        return $signed($urandom_range(128 << FRAC)) - (64 << FRAC);
    endfunction

    // Random part: mostly partial or whole matrix reloads followed by point bursts, some noise.
    task automatic random_phase(int n_items);
        int sent;
        int order [NUM_COEFS];
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) < 8)
            begin
                foreach (order[i]) order[i] = i;
                order.shuffle();
                for (int i = 0; i < NUM_COEFS; i++)
                begin
                    if ($urandom_range(3) != 0 || sent == 0)
                    begin
                        load_coef(order[i], view_coef(order[i]));
                        sent++;
                    end
                end
                repeat ($urandom_range(15, 5))
                begin
                    project(world_coord(), world_coord(), world_coord());
                    sent++;
                end
            end
            else
            begin
                if ($urandom_range(1))
                    project($urandom, $urandom, $urandom);
                else
                    load_coef($urandom_range(15), $urandom);
                sent++;
            end
        end
        drain();
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero matrix puts every point behind the camera.
        project(0, 0, 0);
        // Simple perspective: x, y, z pass through and w takes z.
        load_coef(0, 1 << FRAC);
        load_coef(5, 1 << FRAC);
        load_coef(10, 1 << FRAC);
        load_coef(14, 1 << FRAC);
        project(1 << FRAC, 1 << FRAC, 2 << FRAC);
        project(0, 0, 1 << FRAC);
        project(MAX_S32, MIN_S32, 1 << FRAC);
        // Just under and exactly at the near threshold.
        project(1 << FRAC, 1 << FRAC, 65);
        project(MIN_S32, MAX_S32, 66);
        project(0, 0, -(1 << FRAC));
        project(MIN_S32, MAX_S32, MAX_S32);
        project(MAX_S32, MAX_S32, MIN_S32);
        // Extreme coefficients in the offset columns.
        load_coef(3, MAX_S32);
        load_coef(7, MIN_S32);
        load_coef(15, MAX_S32);
        project(-1, -1, -1);
        project(0, 0, 0);
        load_coef(15, MIN_S32);
        project(0, 0, MAX_S32);
        drain();

        // Random phases under different viewports and idle patterns.
        write_reg(REG_WIDTH, CFG_W'(1));
        write_reg(REG_HEIGHT, CFG_W'(8192));
        send_idle_pct = 30;
        take_idle_pct = 66;
        random_phase(RAND_ITEMS / 4);

        write_reg(REG_WIDTH, CFG_W'(16383));
        write_reg(REG_HEIGHT, CFG_W'(0));
        send_idle_pct = 66;
        take_idle_pct = 30;
        random_phase(RAND_ITEMS / 4);

        write_reg(REG_WIDTH, CFG_W'(0));
        write_reg(REG_HEIGHT, CFG_W'(16383));
        send_idle_pct = 0;
        take_idle_pct = 0;
        random_phase(RAND_ITEMS / 4);

        write_reg(REG_WIDTH, CFG_W'(640));
        write_reg(REG_HEIGHT, CFG_W'(480));
        random_phase(RAND_ITEMS / 4);

        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
sv/ppts_pkg.sv
sv/ppts_fifo.sv
sv/ppts_front.sv
sv/ppts_back.sv
sv/perspective_project_to_screen.sv
sv/ppts_checker.sv
tb/sv/perspective_project_to_screen_tb.sv
